// File: hdl/mcmt_pkg.sv
// ----------------------------------------------------------------------------
// mcmt_pkg
// Shared types, codes and constants of the MIDI control mapping table.
// ----------------------------------------------------------------------------
package mcmt_pkg;

    // Default number of table entries
    localparam int TABLE_DEPTH_DEF = 32;

    // Depth of the command queue between the front and the back part
    localparam int CMD_QUEUE_DEPTH = 2;

    // Operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CC     = 2'd2;
    localparam logic [1:0] OP_NOTE   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ACTION  = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_FULL    = 2'd2;
    localparam logic [1:0] KIND_NOMATCH = 2'd3;

    // round(n / 127) for 0 <= n < 2^24 is ((n + 63) * DIV127_MUL) >> DIV127_SHIFT
    localparam logic [24:0] DIV127_MUL   = 25'd16909321;
    localparam int          DIV127_SHIFT = 31;
    localparam logic [23:0] DIV127_BIAS  = 24'd63;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         channel;
        logic [6:0]         number;
        logic               is_cc;
        logic [6:0]         level;
        logic [7:0]         action_id;
        logic signed [15:0] min_level;
        logic signed [15:0] max_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         action_code;
        logic signed [15:0] scaled;
        logic               last;
    } t_out_item;

    // Match key of a table entry
    typedef struct packed {
        logic [3:0] chan;
        logic [6:0] num;
        logic       ctl;
    } t_key;

    // One stored mapping, 52 bits
    typedef struct packed {
        t_key               key;
        logic [7:0]         act;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Classified command handed from the front to the back part
    typedef struct packed {
        logic [1:0]         op;
        t_key               key;
        logic [6:0]         level;
        logic [7:0]         act;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
    } t_cmd;

    // Command queue handshake between front and back
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_beat;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN
    } t_bk_state;

endpackage

// File: hdl/mcmt_ram.sv
// ----------------------------------------------------------------------------
// mcmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcmt_ram #(
    parameter int WIDTH = mcmt_pkg::ENTRY_W,
    parameter int DEPTH = mcmt_pkg::TABLE_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mcmt_front.sv
// ----------------------------------------------------------------------------
// mcmt_front
// Input side: accept beats, derive the match key and queue the commands.
// ----------------------------------------------------------------------------
module mcmt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcmt_pkg::t_in_item  i_in,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output mcmt_pkg::t_cmd_beat o_cmd,
    input  logic                i_cmd_pop
);

    localparam int QD  = mcmt_pkg::CMD_QUEUE_DEPTH;
    localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    mcmt_pkg::t_cmd r_q [QD];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QCW-1:0] r_cnt;
    mcmt_pkg::t_cmd n_cmd;
    logic           push;
    logic           pop;
    logic           lookup;

    // Lookups pick controller or note entries from the operation itself
    always_comb begin
        lookup          = (i_in.operation == mcmt_pkg::OP_CC) ||
                          (i_in.operation == mcmt_pkg::OP_NOTE);
        n_cmd.op        = i_in.operation;
        n_cmd.key.chan  = i_in.channel;
        n_cmd.key.num   = i_in.number;
        n_cmd.key.ctl   = lookup ? (i_in.operation == mcmt_pkg::OP_CC) : i_in.is_cc;
        n_cmd.level     = i_in.level;
        n_cmd.act       = i_in.action_id;
        n_cmd.lo        = i_in.min_level;
        n_cmd.hi        = i_in.max_level;
    end

    assign o_in_stall = (r_cnt == QCW'(QD));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_cmd_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPW'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPW'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_cmd.valid = (r_cnt != '0);
    assign o_cmd.cmd   = r_q[r_rp];

endmodule

// File: hdl/mcmt_back.sv
// ----------------------------------------------------------------------------
// mcmt_back
// Execution side: table store, scan sequencer, scaling pipeline, results.
// ----------------------------------------------------------------------------
module mcmt_back #(
    parameter int TABLE_DEPTH = mcmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcmt_pkg::t_cmd_beat i_cmd,
    output logic                o_cmd_pop,
    output mcmt_pkg::t_out_item o_out,
    output logic                o_out_valid,
    input  logic                i_out_stall
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    mcmt_pkg::t_bk_state r_state, n_state;
    mcmt_pkg::t_cmd      r_cmd;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_w;

    // Sequencer outputs
    logic       adv;
    logic       ld_cmd;
    logic       add_we;
    logic       idx_inc;
    logic       iss_vld;
    logic       iss_tok;
    logic [1:0] iss_kind;

    // Stage 1: entry read back
    logic       r_s1_vld, r_s1_tok;
    logic [1:0] r_s1_kind;
    mcmt_pkg::t_entry s1_e;
    logic       s1_key_eq, s1_keep, cmd_lookup, cmd_note, cmd_remove;

    // Stage 2: product
    logic                r_s2_vld, r_s2_tok;
    logic [1:0]          r_s2_kind;
    logic signed [16:0]  r_s2_diff;
    logic signed [15:0]  r_s2_lo;
    logic [7:0]          r_s2_act;
    logic signed [24:0]  s2_prod;
    logic [24:0]         s2_mag;

    // Stage 3: reciprocal multiply
    logic                r_s3_vld, r_s3_tok, r_s3_neg;
    logic [1:0]          r_s3_kind;
    logic [23:0]         r_s3_x;
    logic signed [15:0]  r_s3_lo;
    logic [7:0]          r_s3_act;
    logic [48:0]         s3_rp;

    // Stage 4: offset and result ordering
    logic                r_s4_vld, r_s4_tok, r_s4_neg;
    logic [1:0]          r_s4_kind;
    logic [16:0]         r_s4_q;
    logic signed [15:0]  r_s4_lo;
    logic [7:0]          r_s4_act;
    logic signed [17:0]  s4_sq;
    logic signed [17:0]  s4_sum;

    logic                r_pend_vld, n_pend_vld;
    logic [7:0]          r_pend_act, n_pend_act;
    logic signed [15:0]  r_pend_val, n_pend_val;

    mcmt_pkg::t_out_item r_out, n_out;
    logic                r_out_vld, n_out_ld;

    // RAM port wiring
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [mcmt_pkg::ENTRY_W-1:0] ram_wdata;
    logic [mcmt_pkg::ENTRY_W-1:0] ram_rdata;
    mcmt_pkg::t_entry             add_e;
    logic                         pipe_empty;

    // Freeze the whole back end while the output register is held
    assign adv        = !r_out_vld || !i_out_stall;
    assign pipe_empty = !(r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld);

    assign cmd_remove = (r_cmd.op == mcmt_pkg::OP_REMOVE);
    assign cmd_note   = (r_cmd.op == mcmt_pkg::OP_NOTE);
    assign cmd_lookup = (r_cmd.op == mcmt_pkg::OP_CC) || cmd_note;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcmt_pkg::BK_IDLE: begin
                if (i_cmd.valid && adv) begin
                    n_state = (i_cmd.cmd.op == mcmt_pkg::OP_ADD) ?
                              mcmt_pkg::BK_DRAIN : mcmt_pkg::BK_SCAN;
                end
            end
            mcmt_pkg::BK_SCAN: begin
                if (adv && !(r_idx < r_count)) begin
                    n_state = mcmt_pkg::BK_DRAIN;
                end
            end
            mcmt_pkg::BK_DRAIN: begin
                if (pipe_empty) begin
                    n_state = mcmt_pkg::BK_IDLE;
                end
            end
            default: n_state = mcmt_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        ld_cmd    = 1'b0;
        add_we    = 1'b0;
        idx_inc   = 1'b0;
        iss_vld   = 1'b0;
        iss_tok   = 1'b0;
        iss_kind  = mcmt_pkg::KIND_DONE;
        case (r_state)
            mcmt_pkg::BK_IDLE: begin
                if (i_cmd.valid && adv) begin
                    o_cmd_pop = 1'b1;
                    ld_cmd    = 1'b1;
                    if (i_cmd.cmd.op == mcmt_pkg::OP_ADD) begin
                        iss_vld = 1'b1;
                        iss_tok = 1'b1;
                        if (r_count < CW'(TABLE_DEPTH)) begin
                            add_we   = 1'b1;
                            iss_kind = mcmt_pkg::KIND_DONE;
                        end else begin
                            iss_kind = mcmt_pkg::KIND_FULL;
                        end
                    end
                end
            end
            mcmt_pkg::BK_SCAN: begin
                if (adv) begin
                    iss_vld = 1'b1;
                    if (r_idx < r_count) begin
                        idx_inc = 1'b1;
                    end else begin
                        // close the scan with an end marker
                        iss_tok  = 1'b1;
                        iss_kind = cmd_remove ? mcmt_pkg::KIND_DONE :
                                                mcmt_pkg::KIND_NOMATCH;
                    end
                end
            end
            mcmt_pkg::BK_DRAIN: begin
                iss_vld = 1'b0;
            end
            default: begin
                iss_vld = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Table store
    // ------------------------------------------------------------------
    always_comb begin
        add_e.key = i_cmd.cmd.key;
        add_e.act = i_cmd.cmd.act;
        add_e.lo  = i_cmd.cmd.lo;
        add_e.hi  = i_cmd.cmd.hi;
    end

    assign s1_e      = mcmt_pkg::t_entry'(ram_rdata);
    assign s1_key_eq = (s1_e.key == r_cmd.key);
    assign s1_keep   = r_s1_vld && !r_s1_tok && cmd_remove && !s1_key_eq;

    // Add and compaction never write in the same cycle
    assign ram_we    = add_we || (adv && s1_keep);
    assign ram_waddr = add_we ? r_count[AW-1:0] : r_w[AW-1:0];
    assign ram_wdata = add_we ? add_e : ram_rdata;

    mcmt_ram #(
        .WIDTH (mcmt_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (ld_cmd) begin
            r_cmd <= i_cmd.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcmt_pkg::BK_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_w     <= '0;
        end else begin
            r_state <= n_state;
            if (ld_cmd) begin
                r_idx <= '0;
                r_w   <= '0;
            end else if (idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (adv && s1_keep) begin
                r_w <= r_w + 1'b1;
            end
            if (add_we) begin
                r_count <= r_count + 1'b1;
            end else if (adv && r_s1_vld && r_s1_tok && cmd_remove) begin
                r_count <= r_w;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scaling pipeline
    // ------------------------------------------------------------------
    always_comb begin
        if (cmd_note) begin
            s2_prod = $signed({6'b0, r_cmd.level, 12'b0});
        end else begin
            s2_prod = r_s2_diff * $signed({1'b0, r_cmd.level});
        end
        s2_mag = s2_prod[24] ? 25'(-s2_prod) : 25'(s2_prod);
    end

    assign s3_rp  = {25'b0, r_s3_x} * {24'b0, mcmt_pkg::DIV127_MUL};
    assign s4_sq  = r_s4_neg ? -$signed({1'b0, r_s4_q}) : $signed({1'b0, r_s4_q});
    assign s4_sum = $signed({{2{r_s4_lo[15]}}, r_s4_lo}) + s4_sq;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_tok  <= r_s1_tok;
            r_s2_kind <= r_s1_kind;
            r_s2_diff <= $signed({s1_e.hi[15], s1_e.hi}) - $signed({s1_e.lo[15], s1_e.lo});
            r_s2_lo   <= cmd_note ? 16'sd0 : s1_e.lo;
            r_s2_act  <= s1_e.act;

            r_s3_tok  <= r_s2_tok;
            r_s3_kind <= r_s2_kind;
            r_s3_neg  <= s2_prod[24];
            r_s3_x    <= s2_mag[23:0] + mcmt_pkg::DIV127_BIAS;
            r_s3_lo   <= r_s2_lo;
            r_s3_act  <= r_s2_act;

            r_s4_tok  <= r_s3_tok;
            r_s4_kind <= r_s3_kind;
            r_s4_neg  <= r_s3_neg;
            r_s4_q    <= s3_rp[mcmt_pkg::DIV127_SHIFT +: 17];
            r_s4_lo   <= r_s3_lo;
            r_s4_act  <= r_s3_act;

            r_s1_tok  <= iss_tok;
            r_s1_kind <= iss_kind;
        end
    end

    // ------------------------------------------------------------------
    // Result ordering: hold each hit back one step so the final one
    // can carry the last flag when the end marker arrives
    // ------------------------------------------------------------------
    always_comb begin
        n_out_ld   = 1'b0;
        n_out      = '0;
        n_pend_vld = r_pend_vld;
        n_pend_act = r_pend_act;
        n_pend_val = r_pend_val;
        if (r_s4_vld) begin
            if (!r_s4_tok) begin
                if (r_pend_vld) begin
                    n_out_ld          = 1'b1;
                    n_out.kind        = mcmt_pkg::KIND_ACTION;
                    n_out.action_code = r_pend_act;
                    n_out.scaled      = r_pend_val;
                    n_out.last        = 1'b0;
                end
                n_pend_vld = 1'b1;
                n_pend_act = r_s4_act;
                n_pend_val = s4_sum[15:0];
            end else if (r_s4_kind == mcmt_pkg::KIND_NOMATCH) begin
                n_out_ld   = 1'b1;
                n_out.last = 1'b1;
                if (r_pend_vld) begin
                    n_out.kind        = mcmt_pkg::KIND_ACTION;
                    n_out.action_code = r_pend_act;
                    n_out.scaled      = r_pend_val;
                end else begin
                    n_out.kind = mcmt_pkg::KIND_NOMATCH;
                end
                n_pend_vld = 1'b0;
            end else begin
                n_out_ld   = 1'b1;
                n_out.kind = r_s4_kind;
                n_out.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pend_act <= n_pend_act;
            r_pend_val <= n_pend_val;
            if (n_out_ld) begin
                r_out <= n_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_s4_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else if (adv) begin
            r_s1_vld   <= iss_vld;
            r_s2_vld   <= r_s1_vld && (r_s1_tok || (cmd_lookup && s1_key_eq));
            r_s3_vld   <= r_s2_vld;
            r_s4_vld   <= r_s3_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_ld;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_vld;

`ifndef SYNTH
    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mcmt_pkg::BK_IDLE |-> pipe_empty)
        else $error("back pipeline busy while sequencer idle");

    a_compact_behind_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mcmt_pkg::BK_SCAN |-> r_w <= r_idx)
        else $error("compaction write pointer ahead of scan");

    a_pend_in_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> r_state != mcmt_pkg::BK_IDLE)
        else $error("held hit left over after item end");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind != mcmt_pkg::KIND_ACTION |-> o_out.last)
        else $error("status beat without last flag");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> r_state != mcmt_pkg::BK_IDLE)
        else $error("command taken but sequencer stayed idle");
`endif

endmodule

// File: hdl/midi_control_mapping_table_top.sv
// ----------------------------------------------------------------------------
// midi_control_mapping_table_top
// Ordered MIDI controller/note mapping table with scaled action output.
// ----------------------------------------------------------------------------
// Each input beat is one operation: add an entry, remove every entry with a
// key, look up a control change, or look up a note. Add and remove give one
// status beat (done, or full for an add to a full table). A lookup gives one
// action beat per matching entry in table order, scaled to signed Q3.12, with
// last set on the final one, or a single no-match beat. The back end takes
// the next command only after the item has drained from the scaling
// pipeline. The single read port of the entry store gives one entry per
// cycle during the scan while the output is not stalled, and the four-stage
// scaling pipeline drains at the end of each item; extra hits ride the
// pipeline and do not lengthen the scan. While the output beat is held by
// i_out_stall the back end is frozen. A two-deep command queue lets the
// input side keep taking beats while an item runs.
// The entry store needs no clearing pass after reset: only entries below the
// entry count are ever used.
// ----------------------------------------------------------------------------
module midi_control_mapping_table_top #(
    parameter int TABLE_DEPTH = mcmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input beats
    input  mcmt_pkg::t_in_item  i_in,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    // result beats
    output mcmt_pkg::t_out_item o_out,
    output logic                o_out_valid,
    input  logic                i_out_stall
);

    mcmt_pkg::t_cmd_beat cmd_beat;
    logic                cmd_pop;

    // Front: accept, derive key, queue
    mcmt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd_beat),
        .i_cmd_pop  (cmd_pop)
    );

    // Back: scan the table, scale, order and emit results
    mcmt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_beat),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule
